>>> rtl/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define HBA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define HBA_ASSERT_IMPL(lbl, ante, cons)
`endif

`ifndef SYNTH
`define HBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/hba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hba_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_NO_FIT = 1'b1;

    // bytes of header in front of a payload, and log2 of the word size
    localparam int HDR_BYTES   = 8;
    localparam int WORD_SHIFT  = 3;
    localparam int MIN_WORDS   = 4;
    localparam int TAG_BYTES   = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_F_WALK,
        S_F_WCHK,
        S_F_HCHK,
        S_F_PCHK,
        S_F_NRD,
        S_F_NCHK,
        S_W_H1,
        S_W_F1,
        S_W_H2,
        S_W_F2,
        S_DONE
    } hba_state_t;

endpackage
`default_nettype wire

>>> rtl/hba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hba_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/boundary_tag_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator over a heap of 8-byte words, with a size/used tag in the
// first and last word of every block, kept in one tag RAM with a registered read.
// An allocate walks the blocks from word 0, reading and checking the tag of each
// block looked at, then writes the header and footer tags of the block it takes
// and, on a split, of the free rest, and hands over the word; a free walks to its
// header the same way, then reads its own tag and the tags of the neighbors before
// and after it that lie in the heap, and writes 2 tags. The walk is paced by the
// single read port of the tag RAM. After reset or a heap_bytes write the block
// writes the tags of the one free block before it takes a word; no RAM clearing pass.
module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,   // heap_bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // request_bytes [15:0], payload_offset [30:16]
    input  wire logic        s_tuser,     // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // result_offset [14:0]
    output logic             m_tuser      // status
);
    import hba_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = $clog2(HEAP_WORDS + 1);
    localparam int TW = SW + 1;
    localparam int CW = (AW + 1 > 14) ? AW + 1 : 14;
    localparam int RESET_WORDS = (HEAP_WORDS < 4096) ? HEAP_WORDS : 4096;

    hba_state_t state_reg, state_next;

    logic [CW-1:0] aw_reg, aw_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] need_reg, need_next;
    logic [CW-1:0] h_reg, h_next;
    logic [CW-1:0] sz_reg, sz_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] wr_start_reg, wr_start_next;
    logic [CW-1:0] wr_size_reg, wr_size_next;
    logic          wr_used_reg, wr_used_next;
    logic [CW-1:0] sp_start_reg, sp_start_next;
    logic [CW-1:0] sp_size_reg, sp_size_next;
    logic          has2_reg, has2_next;
    logic          report_reg, report_next;
    logic [14:0]   res_reg, res_next;
    logic          stat_reg, stat_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [14:0]   m_off_reg, m_off_next;
    logic          m_stat_reg, m_stat_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [TW-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0] rd_sz;
    logic          rd_used;
    logic [CW-1:0] cfg_words, cfg_sat;
    logic [14:0]   poff;
    logic [CW-1:0] req_need, hdr_word;
    logic [CW-1:0] wr_end, sp_end, next_hdr;

    hba_ram #(.WIDTH(TW), .DEPTH(HEAP_WORDS)) u_tags (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_sz     = CW'(ram_rdata[TW-1:1]);
    assign rd_used   = ram_rdata[0];
    assign cfg_words = CW'(cfg_wdata[15:WORD_SHIFT]);
    assign cfg_sat   = (cfg_words < CW'(MIN_WORDS)) ? CW'(MIN_WORDS) :
                       (cfg_words > CW'(HEAP_WORDS)) ? CW'(HEAP_WORDS) : cfg_words;
    assign poff      = s_tdata[30:16];
    assign req_need  = CW'((17'(s_tdata[15:0]) + 17'(TAG_BYTES + 7)) >> WORD_SHIFT);
    assign hdr_word  = CW'(poff[14:WORD_SHIFT]) - CW'(1);
    assign wr_end    = wr_start_reg + wr_size_reg - CW'(1);
    assign sp_end    = sp_start_reg + sp_size_reg - CW'(1);
    assign next_hdr  = h_reg + sz_reg;

    assign s_tready = (state_reg == S_IDLE) && !cfg_we;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_off_reg};
    assign m_tuser  = m_stat_reg;

    always_comb begin
        state_next    = state_reg;
        aw_next       = aw_reg;
        b_next        = b_reg;
        need_next     = need_reg;
        h_next        = h_reg;
        sz_next       = sz_reg;
        start_next    = start_reg;
        total_next    = total_reg;
        wr_start_next = wr_start_reg;
        wr_size_next  = wr_size_reg;
        wr_used_next  = wr_used_reg;
        sp_start_next = sp_start_reg;
        sp_size_next  = sp_size_reg;
        has2_next     = has2_reg;
        report_next   = report_reg;
        res_next      = res_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_off_next    = m_off_reg;
        m_stat_next   = m_stat_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    res_next  = '0;
                    stat_next = STATUS_DONE;
                    b_next    = '0;
                    if (s_tuser == OP_ALLOC) begin
                        need_next  = req_need;
                        state_next = S_A_RD;
                    end else if (poff < 15'(HDR_BYTES) || poff[WORD_SHIFT-1:0] != '0) begin
                        state_next = S_DONE;
                    end else if (hdr_word >= aw_reg) begin
                        state_next = S_DONE;
                    end else begin
                        h_next     = hdr_word;
                        state_next = S_F_WALK;
                    end
                end
            end
            S_A_RD: begin
                if (b_reg < aw_reg && need_reg <= aw_reg - b_reg) begin
                    ram_raddr  = b_reg[AW-1:0];
                    state_next = S_A_CHK;
                end else begin
                    stat_next  = STATUS_NO_FIT;
                    state_next = S_DONE;
                end
            end
            S_A_CHK: begin
                if (rd_sz == '0) begin
                    stat_next  = STATUS_NO_FIT;
                    state_next = S_DONE;
                end else if (!rd_used && rd_sz >= need_reg) begin
                    wr_start_next = b_reg;
                    wr_size_next  = need_reg;
                    wr_used_next  = 1'b1;
                    has2_next     = rd_sz > need_reg;
                    sp_start_next = b_reg + need_reg;
                    sp_size_next  = rd_sz - need_reg;
                    report_next   = 1'b1;
                    res_next      = 15'({b_reg + CW'(1), 3'b000});
                    state_next    = S_W_H1;
                end else begin
                    b_next     = b_reg + rd_sz;
                    state_next = S_A_RD;
                end
            end
            S_F_WALK: begin
                if (b_reg < h_reg) begin
                    ram_raddr  = b_reg[AW-1:0];
                    state_next = S_F_WCHK;
                end else if (b_reg != h_reg) begin
                    state_next = S_DONE;
                end else begin
                    ram_raddr  = h_reg[AW-1:0];
                    state_next = S_F_HCHK;
                end
            end
            S_F_WCHK: begin
                if (rd_sz == '0) begin
                    state_next = S_DONE;
                end else begin
                    b_next     = b_reg + rd_sz;
                    state_next = S_F_WALK;
                end
            end
            S_F_HCHK: begin
                if (!rd_used || rd_sz == '0 || rd_sz > aw_reg - h_reg) begin
                    state_next = S_DONE;
                end else begin
                    sz_next    = rd_sz;
                    start_next = h_reg;
                    total_next = rd_sz;
                    if (h_reg != '0) begin
                        ram_raddr  = AW'(h_reg - CW'(1));
                        state_next = S_F_PCHK;
                    end else begin
                        state_next = S_F_NRD;
                    end
                end
            end
            S_F_PCHK: begin
                // merge with a free block just before
                if (!rd_used && rd_sz != '0 && rd_sz <= h_reg) begin
                    start_next = h_reg - rd_sz;
                    total_next = total_reg + rd_sz;
                end
                state_next = S_F_NRD;
            end
            S_F_NRD: begin
                wr_start_next = start_reg;
                wr_size_next  = total_reg;
                wr_used_next  = 1'b0;
                has2_next     = 1'b0;
                report_next   = 1'b1;
                if (next_hdr < aw_reg) begin
                    ram_raddr  = next_hdr[AW-1:0];
                    state_next = S_F_NCHK;
                end else begin
                    state_next = S_W_H1;
                end
            end
            S_F_NCHK: begin
                // merge with a free block just after
                if (!rd_used && rd_sz != '0 && rd_sz <= aw_reg - next_hdr) begin
                    wr_size_next = total_reg + rd_sz;
                end
                state_next = S_W_H1;
            end
            S_W_H1: begin
                ram_we     = 1'b1;
                ram_waddr  = wr_start_reg[AW-1:0];
                ram_wdata  = {wr_size_reg[SW-1:0], wr_used_reg};
                state_next = S_W_F1;
            end
            S_W_F1: begin
                ram_we    = 1'b1;
                ram_waddr = wr_end[AW-1:0];
                ram_wdata = {wr_size_reg[SW-1:0], wr_used_reg};
                if (has2_reg) begin
                    state_next = S_W_H2;
                end else if (report_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_W_H2: begin
                ram_we     = 1'b1;
                ram_waddr  = sp_start_reg[AW-1:0];
                ram_wdata  = {sp_size_reg[SW-1:0], 1'b0};
                state_next = S_W_F2;
            end
            S_W_F2: begin
                ram_we     = 1'b1;
                ram_waddr  = sp_end[AW-1:0];
                ram_wdata  = {sp_size_reg[SW-1:0], 1'b0};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_off_next    = res_reg;
                    m_stat_next   = stat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // heap size write rebuilds the heap as one free block
        if (cfg_we) begin
            aw_next       = cfg_sat;
            wr_start_next = '0;
            wr_size_next  = cfg_sat;
            wr_used_next  = 1'b0;
            has2_next     = 1'b0;
            report_next   = 1'b0;
            state_next    = S_W_H1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_W_H1;
            aw_reg       <= CW'(RESET_WORDS);
            wr_start_reg <= '0;
            wr_size_reg  <= CW'(RESET_WORDS);
            wr_used_reg  <= 1'b0;
            has2_reg     <= 1'b0;
            report_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            aw_reg       <= aw_next;
            wr_start_reg <= wr_start_next;
            wr_size_reg  <= wr_size_next;
            wr_used_reg  <= wr_used_next;
            has2_reg     <= has2_next;
            report_reg   <= report_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg        <= b_next;
        need_reg     <= need_next;
        h_reg        <= h_next;
        sz_reg       <= sz_next;
        start_reg    <= start_next;
        total_reg    <= total_next;
        sp_start_reg <= sp_start_next;
        sp_size_reg  <= sp_size_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        m_off_reg    <= m_off_next;
        m_stat_reg   <= m_stat_next;
    end

    `HBA_ASSERT_IMPL(a_tag_write_in_heap, ram_we, CW'(ram_waddr) < aw_reg)
    `HBA_ASSERT_IMPL(a_walk_in_heap, state_reg == S_A_CHK, b_reg < aw_reg)
    `HBA_ASSERT_IMPL(a_no_accept_while_writing, ram_we, !(s_tvalid && s_tready))
    `HBA_ASSERT_NEXT(a_done_delivers, state_reg == S_DONE && !cfg_we && !m_tvalid_reg, m_tvalid_reg)

endmodule
`default_nettype wire
